FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset disable and a custom message
`define RCFP_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion with a generic message
`define RCFP_ASSERT(lbl, clk, rst_n, prop) \
    `RCFP_ASSERT_MSG(lbl, clk, rst_n, prop, "rcfp assertion failed")

`endif

FILE: hdl/rcfp_pkg.sv
// constants, types and command/status structs of the frame parser
// no dependencies; imported by every module of the block
`default_nettype none

package rcfp_pkg;

    // frame layout
    localparam int NUM_CHANNELS = 14;
    localparam int STG_IDX_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CHAN_IDX_W   = 4;
    localparam int POS_W        = 5;
    localparam int VAL_W        = 16;
    localparam int BYTE_W       = 8;

    localparam logic [BYTE_W-1:0] HDR0 = 8'h20;
    localparam logic [BYTE_W-1:0] HDR1 = 8'h40;

    localparam logic [POS_W-1:0] POS_HUNT  = 5'd0;
    localparam logic [POS_W-1:0] POS_HDR1  = 5'd1;
    localparam logic [POS_W-1:0] POS_DATA0 = 5'd2;
    localparam logic [POS_W-1:0] POS_CK_LO = 5'd30;
    localparam logic [POS_W-1:0] POS_CK_HI = 5'd31;

    // checksum seed and value after the first header byte
    localparam logic [VAL_W-1:0] CK_SEED = 16'hFFFF;
    localparam logic [VAL_W-1:0] CK_INIT = CK_SEED - VAL_W'(HDR0);

    // configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_MAX = 1'd1;
    localparam logic [VAL_W-1:0] CLAMP_MIN_RST = 16'd1000;
    localparam logic [VAL_W-1:0] CLAMP_MAX_RST = 16'd2000;

    localparam logic [STG_IDX_W-1:0] LAST_STG = STG_IDX_W'(NUM_CHANNELS - 1);

    typedef logic [STG_IDX_W-1:0] t_stg_idx;

    // controller to datapath
    typedef struct packed {
        logic     ck_init;
        logic     ck_sub;
        logic     hold_lo;
        logic     stage_we;
        t_stg_idx stage_addr;
        logic     out_load;
        t_stg_idx out_addr;
        logic     out_last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic hdr0_match;
        logic hdr1_match;
        logic ck_match;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: hdl/rcfp_ifs.sv
// valid/ready channel interfaces: received bytes in, channel values out
// depends on rcfp_pkg for field widths
`default_nettype none

interface rcfp_byte_if
    import rcfp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface rcfp_chan_if
    import rcfp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CHAN_IDX_W-1:0] channel_index;
    logic [VAL_W-1:0]      channel_value;
    logic                  last_channel;

    modport source (output valid, output channel_index, output channel_value,
                    output last_channel, input ready);
    modport sink (input valid, input channel_index, input channel_value,
                  input last_channel, output ready);
endinterface

`default_nettype wire

FILE: hdl/rcfp_ctrl.sv
// frame parser controller: frame position tracking and emission sequencing
// depends on rcfp_pkg
`default_nettype none

module rcfp_ctrl
    import rcfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    localparam logic ST_RECV = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic             r_state, n_state;
    logic [POS_W-1:0] r_pos, n_pos;
    t_stg_idx         r_cnt, n_cnt;

    logic                  accept;
    logic [CHAN_IDX_W-1:0] word_idx;

    assign o_in_ready = (r_state == ST_RECV);
    assign accept     = o_in_ready && i_in_valid;
    assign word_idx   = CHAN_IDX_W'(r_pos[POS_W-1:1]) - CHAN_IDX_W'(1);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.stage_addr = word_idx[STG_IDX_W-1:0];
        o_cmd.out_addr   = r_cnt;
        o_cmd.out_last   = (r_cnt == LAST_STG);
        case (r_state)
            ST_RECV: begin
                if (accept) begin
                    if (r_pos == POS_HUNT) begin
                        if (i_status.hdr0_match) begin
                            o_cmd.ck_init = 1'b1;
                            n_pos = POS_HDR1;
                        end
                    end else if (r_pos == POS_HDR1) begin
                        if (i_status.hdr1_match) begin
                            o_cmd.ck_sub = 1'b1;
                            n_pos = POS_DATA0;
                        end else begin
                            n_pos = POS_HUNT;
                        end
                    end else if (r_pos == POS_CK_LO) begin
                        o_cmd.hold_lo = 1'b1;
                        n_pos = POS_CK_HI;
                    end else if (r_pos == POS_CK_HI) begin
                        n_pos = POS_HUNT;
                        if (i_status.ck_match) begin
                            n_state = ST_EMIT;
                            n_cnt   = '0;
                        end
                    end else begin
                        o_cmd.ck_sub = 1'b1;
                        if (!r_pos[0]) begin
                            o_cmd.hold_lo = 1'b1;
                        end else if (word_idx < CHAN_IDX_W'(NUM_CHANNELS)) begin
                            o_cmd.stage_we = 1'b1;
                        end
                        n_pos = r_pos + POS_W'(1);
                    end
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_cnt == LAST_STG) begin
                        n_state = ST_RECV;
                    end else begin
                        n_cnt = r_cnt + STG_IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_RECV;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RECV;
            r_pos   <= POS_HUNT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rcfp_dp.sv
// frame parser datapath: checksum, byte pairing, clamp, staging, output register
// depends on rcfp_pkg
`default_nettype none

module rcfp_dp
    import rcfp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [VAL_W-1:0]      i_cfg_data,
    input  wire logic [BYTE_W-1:0]     i_rx_byte,
    input  wire logic                  i_out_ready,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_status                 o_status,
    output logic                       o_out_valid,
    output logic [CHAN_IDX_W-1:0]      o_out_index,
    output logic [VAL_W-1:0]           o_out_value,
    output logic                       o_out_last
);

    logic [VAL_W-1:0]  r_clamp_min;
    logic [VAL_W-1:0]  r_clamp_max;
    logic [VAL_W-1:0]  r_cksum;
    logic [BYTE_W-1:0] r_held;
    logic [VAL_W-1:0]  r_stage [NUM_CHANNELS];
    logic              r_out_valid;
    logic [CHAN_IDX_W-1:0] r_out_index;
    logic [VAL_W-1:0]  r_out_value;
    logic              r_out_last;

    logic [VAL_W-1:0] raw_word;
    logic [VAL_W-1:0] lo_fixed;
    logic [VAL_W-1:0] clamped;

    // word from current byte and held low byte, clamped min first then max
    assign raw_word = {i_rx_byte, r_held};
    assign lo_fixed = (raw_word < r_clamp_min) ? r_clamp_min : raw_word;
    assign clamped  = (lo_fixed > r_clamp_max) ? r_clamp_max : lo_fixed;

    // status to controller
    assign o_status.hdr0_match = (i_rx_byte == HDR0);
    assign o_status.hdr1_match = (i_rx_byte == HDR1);
    assign o_status.ck_match   = (raw_word == r_cksum);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_min <= CLAMP_MIN_RST;
            r_clamp_max <= CLAMP_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CLAMP_MIN: r_clamp_min <= i_cfg_data;
                CFG_CLAMP_MAX: r_clamp_max <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // running checksum and held low byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cksum <= CK_SEED;
            r_held  <= '0;
        end else begin
            if (i_cmd.ck_init) begin
                r_cksum <= CK_INIT;
            end else if (i_cmd.ck_sub) begin
                r_cksum <= r_cksum - VAL_W'(i_rx_byte);
            end
            if (i_cmd.hold_lo) begin
                r_held <= i_rx_byte;
            end
        end
    end

    // staged channel values
    always_ff @(posedge i_clk) begin
        if (i_cmd.stage_we) begin
            r_stage[i_cmd.stage_addr] <= clamped;
        end
    end

    // output register, loaded from the staging store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_index <= CHAN_IDX_W'(i_cmd.out_addr);
            r_out_value <= r_stage[i_cmd.out_addr];
            r_out_last  <= i_cmd.out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

FILE: hdl/rc_channel_frame_parser.sv
// top level of the receiver frame parser: controller plus datapath
// depends on rcfp_pkg, rcfp_ifs, rcfp_ctrl, rcfp_dp
//
// Usage: one received serial byte enters per item on i_rx. The parser hunts
// for header bytes 0x20 0x40, then collects 14 little-endian channel words
// and a little-endian checksum, 32 bytes per frame. Each word is clamped to
// [clamp_min, clamp_max] (registers 0 and 1 on the write port) and staged.
// Throughput: while receiving, one byte is taken every cycle. When the last
// checksum byte matches, i_rx.ready drops and the 14 staged values leave on
// o_ch, one per cycle while o_ch is ready, through the output register, the
// last one marked by last_channel. The first value appears once the controller
// has entered its emission state and loaded the output register; the emission
// sequencer sets the input stall length. A frame with a bad checksum gives no
// items. When o_ch stalls, emission pauses with the pending value held; byte
// intake resumes after the marked item is loaded, even if it still waits to be
// taken.
// Reset (synchronous, active low): hunt state, checksum 0xFFFF, clamp
// bounds 1000 and 2000, output empty.
`default_nettype none

module rc_channel_frame_parser
    import rcfp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [VAL_W-1:0]     i_cfg_data,
    rcfp_byte_if.sink                 i_rx,
    rcfp_chan_if.source               o_ch
);

    t_dp_cmd    cmd;
    t_dp_status status;

    rcfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rx.valid),
        .o_in_ready (i_rx.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rcfp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_rx_byte   (i_rx.rx_byte),
        .i_out_ready (o_ch.ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_ch.valid),
        .o_out_index (o_ch.channel_index),
        .o_out_value (o_ch.channel_value),
        .o_out_last  (o_ch.last_channel)
    );

endmodule

`default_nettype wire

FILE: hdl/rcfp_checker.sv
// port-level checks of the frame parser, bound to the top level
// depends on rcfp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rcfp_checker
    import rcfp_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  i_in_ready,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [CHAN_IDX_W-1:0] i_out_index,
    input wire logic [VAL_W-1:0]      i_out_value,
    input wire logic                  i_out_last
);

    // stalled item holds
    `RCFP_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_index) && $stable(i_out_value) && $stable(i_out_last)))

    // marker sits on the final channel only
    `RCFP_ASSERT(a_last_idx, i_clk, i_rst_n, i_out_valid |-> (i_out_last == (i_out_index == CHAN_IDX_W'(NUM_CHANNELS - 1))))

    // burst runs without gaps
    `RCFP_ASSERT(a_burst_gapless, i_clk, i_rst_n, (i_out_valid && i_out_ready && !i_out_last) |=> (i_out_valid && (i_out_index == $past(i_out_index) + CHAN_IDX_W'(1))))

    // intake stops only after a byte was taken
    `RCFP_ASSERT(a_stall_cause, i_clk, i_rst_n, $fell(i_in_ready) |-> $past(i_in_valid && i_in_ready))

endmodule

bind rc_channel_frame_parser rcfp_checker u_rcfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_rx.valid),
    .i_in_ready  (i_rx.ready),
    .i_out_valid (o_ch.valid),
    .i_out_ready (o_ch.ready),
    .i_out_index (o_ch.channel_index),
    .i_out_value (o_ch.channel_value),
    .i_out_last  (o_ch.last_channel)
);

`default_nettype wire

FILE: verif/tb_rc_channel_frame_parser.sv
// testbench of rc_channel_frame_parser: frames of received bytes in, clamped channel values out
// depends on rcfp_pkg, rcfp_ifs and the parser rtl; a scoreboard class predicts every burst
// random valid/ready idling on both channels, clamp bounds changed between phases
`default_nettype none

module tb_rc_channel_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import rcfp_pkg::*;

    localparam int FRAME_WORDS = 14;
    localparam int FRAME_LEN   = 32;
    localparam int HOLD_OFF    = 300;
    localparam int SETTLE      = 8;
    localparam int PHASE_BYTES = 48;
    localparam int NUM_PHASES  = 7;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct {
        logic [CHAN_IDX_W-1:0] index;
        logic [VAL_W-1:0]      value;
        logic                  last;
    } chan_item_t;

    // frame decoder prediction and queue of channel items still to come
    class channel_scoreboard;
        logic [VAL_W-1:0]  clamp_lo;
        logic [VAL_W-1:0]  clamp_hi;
        logic [POS_W-1:0]  frame_pos;
        logic [VAL_W-1:0]  ck_left;
        logic [BYTE_W-1:0] low_byte;
        logic [VAL_W-1:0]  staged [NUM_CHANNELS];
        chan_item_t        expected_q [$];
        int                errors;

        function new();
            clamp_lo  = CLAMP_MIN_RST;
            clamp_hi  = CLAMP_MAX_RST;
            frame_pos = POS_HUNT;
            ck_left   = CK_SEED;
            low_byte  = '0;
            foreach (staged[i]) staged[i] = '0;
            errors = 0;
        endfunction

        function void set_bounds(input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi);
            clamp_lo = lo;
            clamp_hi = hi;
        endfunction

        // minimum first, then maximum: inverted bounds give clamp_hi
        function logic [VAL_W-1:0] clamp(input logic [VAL_W-1:0] v);
            logic [VAL_W-1:0] r;
            r = v;
            if (r < clamp_lo) r = clamp_lo;
            if (r > clamp_hi) r = clamp_hi;
            return r;
        endfunction

        // one accepted received byte
        function void note_byte(input logic [BYTE_W-1:0] b);
            int               slot;
            logic [VAL_W-1:0] rx_ck;
            chan_item_t       item;
            slot = int'(frame_pos) / 2 - 1;
            case (frame_pos)
                POS_HUNT: begin
                    if (b == HDR0) begin
                        ck_left   = CK_INIT;
                        frame_pos = POS_HDR1;
                    end
                end
                POS_HDR1: begin
                    // a wrong second header byte is consumed, not rechecked
                    if (b == HDR1) begin
                        ck_left   = ck_left - VAL_W'(b);
                        frame_pos = POS_DATA0;
                    end else begin
                        frame_pos = POS_HUNT;
                    end
                end
                POS_CK_LO: begin
                    low_byte  = b;
                    frame_pos = POS_CK_HI;
                end
                POS_CK_HI: begin
                    rx_ck     = {b, low_byte};
                    frame_pos = POS_HUNT;
                    if (rx_ck == ck_left) begin
                        for (int i = 0; i < NUM_CHANNELS; i++) begin
                            item.index = CHAN_IDX_W'(i);
                            item.value = staged[i];
                            item.last  = (i == NUM_CHANNELS - 1);
                            expected_q.push_back(item);
                        end
                    end
                end
                default: begin
                    // checksum runs over raw bytes, staging stores clamped words
                    if (!frame_pos[0]) begin
                        low_byte = b;
                    end else if (slot < NUM_CHANNELS) begin
                        staged[slot] = clamp({b, low_byte});
                    end
                    ck_left   = ck_left - VAL_W'(b);
                    frame_pos = frame_pos + 1'b1;
                end
            endcase
        endfunction

        // one accepted channel item against the oldest expectation
        function void check_channel(input chan_item_t got);
            chan_item_t want;
            if (expected_q.size() == 0) begin
                $error("channel item with nothing expected: index %0d value %0d last %0d",
                       got.index, got.value, got.last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.index !== want.index) begin
                $error("channel_index: expected %0d, got %0d", want.index, got.index);
                errors++;
            end
            if (got.value !== want.value) begin
                $error("channel_value: expected %0d, got %0d", want.value, got.value);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_channel: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [VAL_W-1:0]     cfg_data;

    rcfp_byte_if rx_if ();
    rcfp_chan_if ch_if ();

    rc_channel_frame_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_rx       (rx_if),
        .o_ch       (ch_if)
    );

    channel_scoreboard sb = new();

    bit               send_gaps;
    bit               recv_gaps;
    bit               hold_off_req;
    int unsigned      cycle_count = 0;
    logic [VAL_W-1:0] words [FRAME_WORDS];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // output side: random stalls, one long hold-off on request
    initial begin
        int stall;
        ch_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                ch_if.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end else if (recv_gaps) begin
                stall = $urandom_range(0, 4);
                if (stall > 0) begin
                    ch_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            ch_if.ready <= 1'b1;
            do @(posedge i_clk); while (!ch_if.valid);
        end
    end

    // channel item monitor
    always @(posedge i_clk) begin
        if (i_rst_n && ch_if.valid && ch_if.ready) begin
            sb.check_channel(chan_item_t'{ch_if.channel_index, ch_if.channel_value,
                                          ch_if.last_channel});
        end
    end

    // one received byte, with a random gap in front of it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = send_gaps ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        sb.note_byte(b);
    endtask

    // full 32-byte frame, checksum optionally spoiled by one bit
    task automatic send_frame(input logic [VAL_W-1:0] w [FRAME_WORDS], input bit bad_ck);
        logic [BYTE_W-1:0] fb [FRAME_LEN];
        logic [VAL_W-1:0]  sum;
        logic [VAL_W-1:0]  ck;
        fb[0] = HDR0;
        fb[1] = HDR1;
        for (int i = 0; i < FRAME_WORDS; i++) begin
            fb[2 + 2 * i] = w[i][7:0];
            fb[3 + 2 * i] = w[i][15:8];
        end
        sum = '0;
        for (int i = 0; i < int'(POS_CK_LO); i++) sum = sum + VAL_W'(fb[i]);
        ck = CK_SEED - sum;
        fb[POS_CK_LO] = ck[7:0];
        fb[POS_CK_HI] = ck[15:8];
        if (bad_ck) begin
            fb[int'(POS_CK_LO) + $urandom_range(0, 1)] ^= BYTE_W'(1) << $urandom_range(0, 7);
        end
        foreach (fb[i]) send_byte(fb[i]);
    endtask

    // channel word, often close to the current bounds
    function automatic logic [VAL_W-1:0] pick_word();
        int v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom_range(0, 65535);
            2: v = int'(sb.clamp_lo) + int'($urandom_range(0, 4)) - 2;
            3: v = int'(sb.clamp_hi) + int'($urandom_range(0, 4)) - 2;
            4: v = $urandom_range(0, 1) ? 65535 : 0;
            default: v = $urandom_range(0, 4095);
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return VAL_W'(v);
    endfunction

    task automatic fill_words();
        foreach (words[i]) words[i] = pick_word();
    endtask

    // mostly good frames, some bad checksums, broken headers, cut frames and noise
    task automatic random_sequence(input bit allow_gaps, inout int sent);
        int                kind;
        int                n;
        logic [BYTE_W-1:0] b;
        send_gaps = allow_gaps && ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(BYTE_W'($urandom));
        end
        kind = $urandom_range(0, 9);
        fill_words();
        if (kind <= 7) begin
            send_frame(words, kind == 7);
            sent += FRAME_LEN;
        end else if (kind == 8) begin
            send_byte(HDR0);
            do b = BYTE_W'($urandom); while (b == HDR1);
            send_byte(b);
            sent += 2;
        end else begin
            send_byte(HDR0);
            send_byte(HDR1);
            n = $urandom_range(1, 20);
            repeat (n) send_byte(BYTE_W'($urandom));
            sent += n + 2;
        end
    endtask

    // back to hunting, then wait for every expected item and let the block settle
    task automatic end_phase();
        while (sb.frame_pos != POS_HUNT) send_byte('0);
        rx_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_bounds(input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_CLAMP_MIN;
        cfg_data <= lo;
        @(posedge i_clk);
        cfg_idx  <= CFG_CLAMP_MAX;
        cfg_data <= hi;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        sb.set_bounds(lo, hi);
    endtask

    // main sequence
    initial begin
        int               sent;
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= CFG_CLAMP_MIN;
        cfg_data      <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        send_gaps     = 1'b1;
        recv_gaps     = 1'b1;
        hold_off_req  = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bytes ignored while hunting
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HDR1);
        // wrong second header: the repeated first header is swallowed
        send_byte(HDR0);
        send_byte(HDR0);
        send_byte(HDR1);
        send_byte(HDR0);
        send_byte(8'h00);
        // extremes and values around the reset bounds, good then bad checksum
        words = '{16'h0000, 16'hFFFF, 16'd999, 16'd1000, 16'd1001, 16'd1999, 16'd2000,
                  16'd2001, 16'h8000, 16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA, 16'd1500};
        send_frame(words, 1'b0);
        send_frame(words, 1'b1);
        end_phase();

        // random phases, each under its own clamp bounds; byte budget is cumulative
        sent = 0;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                1: set_bounds(16'd0, 16'hFFFF);
                2: set_bounds(16'hFFFF, 16'd0);
                3: set_bounds(16'd0, 16'd0);
                4: set_bounds(16'hFFFF, 16'hFFFF);
                5: begin
                    lo = VAL_W'($urandom);
                    hi = VAL_W'($urandom_range(int'(lo), 65535));
                    set_bounds(lo, hi);
                end
                6: set_bounds(VAL_W'($urandom), VAL_W'($urandom));
                default: ;
            endcase
            recv_gaps = (phase != 1);
            if (phase == 2) begin
                // output held off while good frames keep coming
                hold_off_req = 1'b1;
                send_gaps    = 1'b0;
                fill_words();
                send_frame(words, 1'b0);
                fill_words();
                send_frame(words, 1'b0);
                sent += 2 * FRAME_LEN;
            end
            while (sent < (phase + 1) * PHASE_BYTES) random_sequence(phase != 1, sent);
            end_phase();
        end

        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
